@@ hw/rtl/bfr_pkg.sv @@
package bfr_pkg;

    // Field and buffer sizes
    localparam int FIELD_W       = 64;
    localparam int BYTE_W        = 8;
    localparam int BUF_BYTES_DEF = 256;

    // Command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REWIND = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Command word
    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [6:0]        bit_count;
        logic              is_signed;
        logic [2:0]        start_margin;
    } in_word_t;

    // Response word
    typedef struct packed {
        logic signed [FIELD_W-1:0] field_value;
        logic                      overrun;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic extract;
        logic load_out;
    } bfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic last_seg;
    } bfr_stat_t;

endpackage

@@ hw/rtl/bfr_ctrl.sv @@
module bfr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [1:0]           cmd,
    output logic                 cmd_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  bfr_pkg::bfr_stat_t   stat,
    output bfr_pkg::bfr_cmd_t    ctl
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SETUP   = 2'd1;
    localparam logic [1:0] ST_EXTRACT = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // Handshake and commands
    always_comb
    begin
        cmd_stall    = (state_reg != ST_IDLE);
        ctl.accept   = cmd_valid && !cmd_stall;
        ctl.setup    = (state_reg == ST_SETUP);
        ctl.extract  = (state_reg == ST_EXTRACT);
        ctl.load_out = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.accept && (cmd == bfr_pkg::CMD_READ))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = stat.skip ? ST_FINISH : ST_EXTRACT;
            end
            ST_EXTRACT:
            begin
                if (stat.last_seg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (ctl.load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ hw/rtl/bfr_dp.sv @@
module bfr_dp
#(
    parameter int BUF_BYTES = bfr_pkg::BUF_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_data,
    input  bfr_pkg::in_word_t    cmd_word,
    input  bfr_pkg::bfr_cmd_t    ctl,
    output bfr_pkg::bfr_stat_t   stat,
    output bfr_pkg::out_word_t   rsp_word
);

    localparam int AW  = $clog2(BUF_BYTES);
    localparam int LW  = AW + 1;
    localparam int LFW = LW + 4;
    localparam int FW  = bfr_pkg::FIELD_W;
    localparam int BW  = bfr_pkg::BYTE_W;
    localparam logic [LW-1:0] BUF_MAX = LW'(BUF_BYTES);

    // Byte buffer
    logic [BW-1:0] mem [BUF_BYTES];
    logic [BW-1:0] q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    // Stream state
    logic [1:0]    order_reg, order_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [2:0]    bp_reg, bp_next;
    logic [2:0]    mg_reg, mg_next;
    logic          ovf_reg, ovf_next;

    // Per-read working registers
    logic [6:0]    cnt_reg, cnt_next;
    logic [6:0]    req_reg, req_next;
    logic          sgn_reg, sgn_next;
    logic [6:0]    shift_reg, shift_next;
    logic [FW-1:0] acc_reg, acc_next;
    logic [6:0]    off_reg, off_next;
    logic          zero_reg, zero_next;
    bfr_pkg::out_word_t out_reg, out_next;

    // Setup terms
    logic [LW-1:0]         diff;
    logic signed [LFW-1:0] left;
    logic signed [LFW-1:0] cnt_s;
    logic                  short_rd;
    logic                  empty;
    logic [6:0]            clamp;

    // Segment terms
    logic [3:0]    avail;
    logic          full;
    logic [3:0]    take;
    logic [BW-1:0] mask;
    logic [2:0]    psh;
    logic [2:0]    sh;
    logic [BW-1:0] seg;
    logic [FW-1:0] seg_w;

    // Finish terms
    logic [FW-1:0] val;
    logic [FW-1:0] msb;
    logic [FW-1:0] res;

    // Remaining-bit count, segment extraction and final shift and sign extension
    always_comb
    begin
        diff     = len_reg - idx_reg;
        left     = $signed({1'b0, diff, 3'b000})
                 - $signed({{(LFW-3){1'b0}}, bp_reg})
                 - $signed({{(LFW-3){1'b0}}, mg_reg});
        cnt_s    = $signed({{(LFW-7){1'b0}}, cnt_reg});
        short_rd = (left < cnt_s);
        empty    = left[LFW-1] || (left == '0);
        clamp    = (cmd_word.bit_count > 7'd64) ? 7'd64 : cmd_word.bit_count;

        avail = 4'd8 - {1'b0, bp_reg} - {1'b0, mg_reg};
        full  = ({3'b000, avail} <= cnt_reg);
        take  = full ? avail : cnt_reg[3:0];
        mask  = 8'hFF >> (4'd8 - take);
        psh   = 3'(4'd8 - {1'b0, bp_reg} - cnt_reg[3:0]);
        // MSB-first skips the low margin when it takes the rest of a byte; LSB-first starts at the bit position
        sh    = order_reg[1] ? (full ? mg_reg : psh) : bp_reg;
        seg   = (q_reg >> sh) & mask;
        seg_w = {{(FW-BW){1'b0}}, seg};

        stat.skip     = (cnt_reg == 7'd0) || (short_rd && empty);
        stat.last_seg = (cnt_reg <= {3'b000, avail});

        val = acc_reg << shift_reg;
        msb = sgn_reg ? (FW'(1) << (req_reg - 7'd1)) : '0;
        res = zero_reg ? '0 : ((val ^ msb) - msb);
    end

    // Next-state logic
    always_comb
    begin
        order_next = order_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        bp_next    = bp_reg;
        mg_next    = mg_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        sgn_next   = sgn_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        off_next   = off_reg;
        zero_next  = zero_reg;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_waddr  = len_reg[AW-1:0];

        if (cfg_we)
        begin
            order_next = cfg_data;
        end

        // Command word accepted
        if (ctl.accept)
        begin
            case (cmd_word.cmd)
                bfr_pkg::CMD_APPEND:
                begin
                    if (len_reg < BUF_MAX)
                    begin
                        mem_we   = 1'b1;
                        len_next = len_reg + LW'(1);
                    end
                end
                bfr_pkg::CMD_READ:
                begin
                    cnt_next   = clamp;
                    req_next   = clamp;
                    sgn_next   = cmd_word.is_signed;
                    shift_next = '0;
                    acc_next   = '0;
                    off_next   = '0;
                end
                bfr_pkg::CMD_REWIND:
                begin
                    idx_next = '0;
                    bp_next  = '0;
                    mg_next  = cmd_word.start_margin;
                    ovf_next = 1'b0;
                end
                bfr_pkg::CMD_CLEAR:
                begin
                    idx_next = '0;
                    bp_next  = '0;
                    mg_next  = cmd_word.start_margin;
                    ovf_next = 1'b0;
                    len_next = '0;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end

        // Short-read check
        if (ctl.setup)
        begin
            zero_next = stat.skip;
            if ((cnt_reg != 7'd0) && short_rd)
            begin
                ovf_next = 1'b1;
                if (!empty)
                begin
                    cnt_next   = left[6:0];
                    shift_next = order_reg[0] ? (cnt_reg - left[6:0]) : '0;
                end
            end
        end

        // One byte segment per cycle
        if (ctl.extract)
        begin
            if (order_reg[0])
            begin
                acc_next = (acc_reg << take) | seg_w;
            end
            else
            begin
                acc_next = acc_reg | (seg_w << off_reg);
            end
            off_next = off_reg + {3'b000, take};
            cnt_next = cnt_reg - {3'b000, take};
            if (full)
            begin
                idx_next = idx_reg + LW'(1);
                bp_next  = '0;
                mg_next  = '0;
            end
            else
            begin
                bp_next = bp_reg + cnt_reg[2:0];
            end
        end

        // Shift, sign-extend and load the response
        if (ctl.load_out)
        begin
            out_next.field_value = $signed(res);
            out_next.overrun     = ovf_reg;
        end

        // Prefetch the byte at the next position
        mem_raddr = idx_next[AW-1:0];
    end

    assign rsp_word = out_reg;

    // Buffer memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd_word.data_byte;
        end
        q_reg <= mem[mem_raddr];
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            bp_reg    <= '0;
            mg_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            order_reg <= order_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            bp_reg    <= bp_next;
            mg_reg    <= mg_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        req_reg   <= req_next;
        sgn_reg   <= sgn_next;
        shift_reg <= shift_next;
        acc_reg   <= acc_next;
        off_reg   <= off_next;
        zero_reg  <= zero_next;
        out_reg   <= out_next;
    end

endmodule

@@ hw/rtl/bitstream_field_reader_top.sv @@
// Bit field reader over a byte buffer. Append, rewind and clear words leave the
// block idle. A read word runs a remaining-bit check, then one extract step per
// buffer byte it touches (1 to 9), then the final shift and sign extension: the
// buffer has one read port and the extractor consumes one byte segment per cycle.
// Reads with a zero count or nothing left skip the extract steps. A finished field
// sits in an output register, so append and rewind words are taken while it waits;
// a further read holds in its last cycle until that register is free. order_mode
// (cfg_data) is bit 0 big-endian byte assembly, bit 1 MSB-first within a byte;
// change it only while the block is idle.
module bitstream_field_reader_top
#(
    parameter int BUF_BYTES = bfr_pkg::BUF_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  bfr_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bfr_pkg::out_word_t rsp_word
);

    bfr_pkg::bfr_cmd_t  ctl;
    bfr_pkg::bfr_stat_t stat;

    // Sequencer
    bfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_word.cmd),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Buffer, stream state and extractor
    bfr_dp #(.BUF_BYTES(BUF_BYTES)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_word (cmd_word),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_word (rsp_word)
    );

endmodule

@@ hw/rtl/bfr_checker.sv @@
module bfr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input bfr_pkg::in_word_t  cmd_word,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input bfr_pkg::out_word_t rsp_word
);

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("response word dropped or changed under stall");

    // A read keeps the command side busy while it runs
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd_word.cmd == bfr_pkg::CMD_READ) |=> cmd_stall)
        else $error("command side free right after a read");

    // Non-read words leave the command side free
    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd_word.cmd != bfr_pkg::CMD_READ) |=> !cmd_stall)
        else $error("non-read word stalled the command side");

    // A new response appears as the read ends
    a_rsp_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !cmd_stall && $past(cmd_stall))
        else $error("response raised outside the end of a read");

endmodule

bind bitstream_field_reader_top bfr_checker u_bfr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
